/* rtl/msc_pkg.sv */
package msc_pkg;

  localparam int COMPONENTS = 8;
  localparam int LEVEL_BITS = 8;
  localparam int SCENARIOS  = 64;

  localparam int LANE_W  = 8;
  localparam int LEVELS_W = 64;
  localparam int MASK_W  = 8;
  localparam int ID_W    = 6;
  localparam int CNT_W   = $clog2(SCENARIOS + 1);
  localparam int IDX_W   = (SCENARIOS > 1) ? $clog2(SCENARIOS) : 1;
  localparam int ENTRY_W = LEVELS_W + IDX_W;

  typedef struct packed {
    logic                first_of_set;
    logic [LEVELS_W-1:0] price_levels;
  } msc_in_t;

  typedef struct packed {
    logic [ID_W-1:0] class_id;
    logic [ID_W-1:0] representative;
    logic            new_class;
    logic            overflow;
  } msc_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
    logic emit_ovf;
  } msc_cmd_t;

  typedef struct packed {
    logic full;
    logic hit;
    logic miss;
  } msc_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN
  } msc_state_e;

  function automatic logic [LEVELS_W-1:0] signature_of(
    input logic [LEVELS_W-1:0] levels,
    input logic [MASK_W-1:0]   mask
  );
    logic [LEVELS_W-1:0] sig;
    sig = '0;
    for (int c = 0; c < COMPONENTS; c++) begin
      if (mask[c]) begin
        sig[c*LANE_W +: LEVEL_BITS] = levels[c*LANE_W +: LEVEL_BITS];
      end
    end
    return sig;
  endfunction

endpackage

/* rtl/msc_ram.sv */
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/msc_ctrl.sv */
module msc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  msc_pkg::msc_sts_t sts_i,
  output msc_pkg::msc_cmd_t cmd_o
);
  import msc_pkg::*;

  msc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.full) begin
          cmd_o.emit_ovf = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.miss) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/msc_dp.sv */
module msc_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [msc_pkg::MASK_W-1:0] cfg_data_i,
  input  msc_pkg::msc_in_t         in_i,
  input  msc_pkg::msc_cmd_t        cmd_i,
  output msc_pkg::msc_sts_t        sts_o,
  output logic                     result_valid_o,
  output msc_pkg::msc_out_t        result_o
);
  import msc_pkg::*;

  logic [MASK_W-1:0]   mask_q;
  logic [LEVELS_W-1:0] sig_q;
  logic [CNT_W-1:0]    class_cnt_q, class_cnt_d;
  logic [CNT_W-1:0]    scen_cnt_q, scen_cnt_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    pend_idx_q;
  logic                valid_q;
  msc_out_t            result_q;

  logic                rd_en;
  logic [ENTRY_W-1:0]  rd_data;
  logic                wr_en;
  logic [ENTRY_W-1:0]  wr_data;

  assign rd_en   = cmd_i.scan && (issue_q < class_cnt_q);
  assign wr_en   = cmd_i.finish && !sts_o.hit;
  assign wr_data = {sig_q, scen_cnt_q[IDX_W-1:0]};

  assign sts_o.full = (scen_cnt_q >= CNT_W'(SCENARIOS));
  assign sts_o.hit  = pend_q && (rd_data[ENTRY_W-1:IDX_W] == sig_q);
  assign sts_o.miss = !pend_q && (issue_q == class_cnt_q);

  msc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SCENARIOS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (class_cnt_q[IDX_W-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    class_cnt_d = class_cnt_q;
    scen_cnt_d  = scen_cnt_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    if (cmd_i.load) begin
      if (in_i.first_of_set) begin
        class_cnt_d = '0;
        scen_cnt_d  = '0;
      end
      issue_d = '0;
      pend_d  = 1'b0;
    end else if (cmd_i.scan) begin
      pend_d = rd_en;
      if (rd_en) begin
        issue_d = issue_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        scen_cnt_d = scen_cnt_q + CNT_W'(1);
        if (!sts_o.hit) begin
          class_cnt_d = class_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      class_cnt_q <= '0;
      scen_cnt_q  <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_data_i;
      end
      class_cnt_q <= class_cnt_d;
      scen_cnt_q  <= scen_cnt_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      valid_q     <= cmd_i.finish || cmd_i.emit_ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sig_q <= signature_of(in_i.price_levels, mask_q);
    end
    if (rd_en) begin
      pend_idx_q <= issue_q[IDX_W-1:0];
    end
    if (cmd_i.emit_ovf) begin
      result_q <= '{class_id: '0, representative: '0, new_class: 1'b0, overflow: 1'b1};
    end else if (cmd_i.finish) begin
      if (sts_o.hit) begin
        result_q.class_id       <= ID_W'(pend_idx_q);
        result_q.representative <= ID_W'(rd_data[IDX_W-1:0]);
        result_q.new_class      <= 1'b0;
      end else begin
        result_q.class_id       <= ID_W'(class_cnt_q);
        result_q.representative <= ID_W'(scen_cnt_q);
        result_q.new_class      <= 1'b1;
      end
      result_q.overflow <= 1'b0;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

/* rtl/masked_signature_classifier.sv */
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------------------
// input    | start (in), busy (out)        | in_i: first_of_set, price_levels
// result   | result_valid_o strobe only    | result_o: class_id, representative, flags
// config   | cfg_valid_i, cfg_ready_o      | cfg_data_i: probe_mask
//
// A scenario is taken when start is high and busy is low. On set overflow the
// result strobe follows the check state; otherwise the class table is swept
// in class order until stored class K matches or all C stored classes miss.
// The one registered read port of the class table sets the pace: one stored
// signature per cycle, with the read data registered. The strobe cycle has
// busy low, so a new scenario may start there. Reset clears the counts and the
// probe mask; the class table holds no reset state and is read only where
// written.
// The result receiver cannot stall: each result shows for one cycle only.
module masked_signature_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  msc_pkg::msc_in_t           in_i,
  output logic                       result_valid_o,
  output msc_pkg::msc_out_t          result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [msc_pkg::MASK_W-1:0] cfg_data_i
);
  import msc_pkg::*;

  msc_cmd_t cmd;
  msc_sts_t sts;

  // Take mask writes only between transactions.
  assign cfg_ready_o = !busy;

  // Sequence: load and mask the scenario, check for set overflow, then sweep
  // the stored signatures in class order until a match or the end.
  msc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Hold the counts, the class table and the registered result.
  msc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* rtl/msc_checker.sv */
module msc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input msc_pkg::msc_in_t           in_i,
  input logic                       result_valid_o,
  input msc_pkg::msc_out_t          result_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [msc_pkg::MASK_W-1:0] cfg_data_i
);
  import msc_pkg::*;

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low right after accepted start");

  // No result in the cycle right after acceptance.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result one cycle after start");

  // The result strobe ends the transaction.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  // Overflow results carry zero fields.
  a_ovf_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.overflow) |->
      (result_o.class_id == '0 && result_o.representative == '0 && !result_o.new_class))
    else $error("overflow result with nonzero fields");

  // A result strobe stands alone for one cycle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held two cycles");

endmodule

bind masked_signature_classifier msc_checker u_msc_checker (.*);
